[design/rwsd_pkg.sv]
// Shared types, field widths and reset values for the ring window sum event detector.
package rwsd_pkg;

    // Default geometry of the ring and of the short window.
    localparam int DEPTH_DEFAULT  = 16;
    localparam int WINDOW_DEFAULT = 5;

    // Field widths fixed by the stream format.
    localparam int SAMPLE_W    = 16;
    localparam int SLOT_W      = 4;
    localparam int FILL_W      = 5;
    localparam int EVENT_W     = 2;
    localparam int S_TDATA_W   = 24;
    localparam int M_TDATA_W   = 32;
    localparam int RESULT_PAD_W = M_TDATA_W - (3 * EVENT_W + SAMPLE_W + 1 + FILL_W);

    // Configuration register widths and reset values.
    localparam int MEAN_LIMIT_W = 15;
    localparam int WIN_LIMIT_W  = 18;
    localparam int CFG_INDEX_W  = 2;
    localparam int CFG_DATA_W   = 18;
    localparam logic [MEAN_LIMIT_W-1:0] MEAN_LIMIT_RESET = MEAN_LIMIT_W'(256);
    localparam logic [WIN_LIMIT_W-1:0]  LOW_LIMIT_RESET  = WIN_LIMIT_W'(1280);
    localparam logic [WIN_LIMIT_W-1:0]  HIGH_LIMIT_RESET = WIN_LIMIT_W'(2560);

    // Request kinds carried on the input tuser bit.
    typedef enum logic {
        CMD_PUSH = 1'b0,
        CMD_READ = 1'b1
    } cmd_t;

    // Configuration register indexes.
    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_MEAN_LIMIT = 2'd0,
        REG_LOW_LIMIT  = 2'd1,
        REG_HIGH_LIMIT = 2'd2
    } cfg_reg_t;

    // Three-way event code.
    typedef enum logic [EVENT_W-1:0] {
        EV_NONE  = 2'd0,
        EV_FALSE = 2'd1,
        EV_TRUE  = 2'd2
    } event_t;

    // Request after the ring stage, with everything the sum stage needs.
    typedef struct packed {
        cmd_t                        cmd;
        logic signed [SAMPLE_W-1:0]  sample;
        logic signed [SAMPLE_W-1:0]  leave_sample;
        logic                        sub_old;
        logic                        sub_leave;
        logic                        full_after;
        logic                        win_after;
        logic                        read_ok;
        logic [FILL_W-1:0]           fill;
    } a_item_t;

    // Status passed from the sum stage to the evaluation stage.
    typedef struct packed {
        logic                        full;
        logic                        win_ready;
        logic                        read_ok;
        logic signed [SAMPLE_W-1:0]  read_value;
        logic [FILL_W-1:0]           fill;
    } b_item_t;

    // Result layout, last field in the lowest bits.
    typedef struct packed {
        logic [RESULT_PAD_W-1:0]     pad;
        logic [FILL_W-1:0]           fill_count;
        logic                        read_valid;
        logic signed [SAMPLE_W-1:0]  read_value;
        event_t                      high_window_event;
        event_t                      low_window_event;
        event_t                      mean_event;
    } result_t;

endpackage

[design/ring_window_sum_event_detector_core.sv]
// Ring window sum event detector: top level with configuration registers.
//
// Input channel (s_): one request per handshake. tuser selects a push of a
// signed Q8.8 sample or a read of one physical ring slot. Every request gives
// exactly one result on the m_ channel: the mean event of the full ring, the
// two window events over the last WINDOW pushes, the read slot value with its
// valid flag, and the fill count after the request.
// m_tvalid rises once the request has passed the ring stage, the sum stage and
// the result register. Throughput is one request per cycle while m_tready
// stays high, set by the running sums being updated once per request in the sum
// stage and by the ring memory being read and written at most once per request.
// Each stage holds its request while the next one is full, so a stalled
// receiver fills the three stages before s_tready drops; nothing is lost.
// Reset (aresetn low at a clock edge) empties the pipeline, clears fill count,
// write pointer and both sums, and loads the default limits. The ring
// contents are not cleared; slots are only read once written.
// Configuration writes (cfg_we) update the window limits at the write edge and
// the registered mean bound in the cycle after; they are meant for idle periods.
module ring_window_sum_event_detector_core #(
    parameter int DEPTH  = rwsd_pkg::DEPTH_DEFAULT,
    parameter int WINDOW = rwsd_pkg::WINDOW_DEFAULT
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // [15:0] sample, [19:16] slot_index, [23:20] zero
    input  logic [rwsd_pkg::S_TDATA_W-1:0]      s_tdata,
    // [0] command
    input  logic                                s_tuser,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // [1:0] mean_event, [3:2] low_window_event, [5:4] high_window_event,
    // [21:6] read_value, [22] read_valid, [27:23] fill_count, [31:28] zero
    output logic [rwsd_pkg::M_TDATA_W-1:0]      m_tdata,
    input  logic                                cfg_we,
    input  logic [rwsd_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [rwsd_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import rwsd_pkg::*;

    localparam int TSW = SAMPLE_W + $clog2(DEPTH);
    localparam int WSW = SAMPLE_W + $clog2(WINDOW);

    logic [MEAN_LIMIT_W-1:0]    mean_limit_reg;
    logic [WIN_LIMIT_W-1:0]     low_limit_reg;
    logic [WIN_LIMIT_W-1:0]     high_limit_reg;
    logic                       a_valid;
    a_item_t                    a_item;
    logic signed [SAMPLE_W-1:0] a_mem_data;
    logic                       b_ready;
    logic                       b_valid;
    b_item_t                    b_item;
    logic signed [TSW-1:0]      total;
    logic signed [WSW-1:0]      window;
    logic                       c_ready;
    result_t                    out_view;

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mean_limit_reg <= MEAN_LIMIT_RESET;
            low_limit_reg  <= LOW_LIMIT_RESET;
            high_limit_reg <= HIGH_LIMIT_RESET;
        end else if (cfg_we) begin
            unique case (cfg_reg_t'(cfg_index))
                REG_MEAN_LIMIT: mean_limit_reg <= cfg_data[MEAN_LIMIT_W-1:0];
                REG_LOW_LIMIT:  low_limit_reg  <= cfg_data[WIN_LIMIT_W-1:0];
                REG_HIGH_LIMIT: high_limit_reg <= cfg_data[WIN_LIMIT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    rwsd_ring #(
        .DEPTH  (DEPTH),
        .WINDOW (WINDOW)
    ) u_ring (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_cmd      (cmd_t'(s_tuser)),
        .s_sample   (s_tdata[SAMPLE_W-1:0]),
        .s_slot     (s_tdata[SAMPLE_W+SLOT_W-1:SAMPLE_W]),
        .b_ready    (b_ready),
        .a_valid    (a_valid),
        .a_item     (a_item),
        .a_mem_data (a_mem_data)
    );

    rwsd_accum #(
        .DEPTH  (DEPTH),
        .WINDOW (WINDOW)
    ) u_accum (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .a_valid    (a_valid),
        .a_item     (a_item),
        .a_mem_data (a_mem_data),
        .c_ready    (c_ready),
        .b_ready    (b_ready),
        .b_valid    (b_valid),
        .b_item     (b_item),
        .total      (total),
        .window     (window)
    );

    rwsd_eval #(
        .DEPTH  (DEPTH),
        .WINDOW (WINDOW)
    ) u_eval (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .b_valid    (b_valid),
        .b_item     (b_item),
        .total      (total),
        .window     (window),
        .mean_limit (mean_limit_reg),
        .low_limit  (low_limit_reg),
        .high_limit (high_limit_reg),
        .c_ready    (c_ready),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata)
    );

    assign out_view = result_t'(m_tdata);

    // An accepted request always lands in the ring stage.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> a_valid)
        else $error("accepted request missing from ring stage");

    // Both window events come from the same fill condition.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> ((out_view.low_window_event == EV_NONE) ==
                      (out_view.high_window_event == EV_NONE)))
        else $error("window events disagree on window fill");

    // A full ring implies a full window.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (WINDOW <= DEPTH) && (out_view.mean_event != EV_NONE))
            |-> (out_view.low_window_event != EV_NONE))
        else $error("ring full but window reported not full");

endmodule

[design/rwsd_ring.sv]
// Ring storage, fill count, write pointer and the short window delay line.
module rwsd_ring #(
    parameter int DEPTH  = rwsd_pkg::DEPTH_DEFAULT,
    parameter int WINDOW = rwsd_pkg::WINDOW_DEFAULT
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    input  rwsd_pkg::cmd_t                        s_cmd,
    input  logic signed [rwsd_pkg::SAMPLE_W-1:0]  s_sample,
    input  logic [rwsd_pkg::SLOT_W-1:0]           s_slot,
    input  logic                                  b_ready,
    output logic                                  a_valid,
    output rwsd_pkg::a_item_t                     a_item,
    output logic signed [rwsd_pkg::SAMPLE_W-1:0]  a_mem_data
);
    import rwsd_pkg::*;

    localparam int AW  = $clog2(DEPTH);
    localparam int HCW = $clog2(DEPTH + 1);
    localparam int SW  = (AW > SLOT_W) ? AW : SLOT_W;

    logic signed [SAMPLE_W-1:0] ring_mem [DEPTH];
    logic signed [SAMPLE_W-1:0] win_line_reg [WINDOW];
    logic signed [SAMPLE_W-1:0] rd_data_reg;
    logic [HCW-1:0]             held_reg;
    logic [HCW-1:0]             held_next;
    logic [AW-1:0]              wr_slot_reg;
    logic [AW-1:0]              wr_slot_next;
    logic [AW-1:0]              rd_addr;
    logic [SW-1:0]              slot_wide;
    logic                       a_valid_reg;
    a_item_t                    a_item_reg;
    a_item_t                    item_next;
    logic                       accept;
    logic                       is_push;
    logic                       ring_full;
    logic                       win_full;

    assign s_tready = !a_valid_reg || b_ready;
    assign accept   = s_tvalid && s_tready;
    assign is_push  = (s_cmd == CMD_PUSH);

    // Occupancy and pointer bookkeeping.
    always_comb begin
        ring_full    = (held_reg == HCW'(DEPTH));
        win_full     = (WINDOW <= DEPTH) && (32'(held_reg) >= 32'(WINDOW));
        held_next    = (is_push && !ring_full) ? held_reg + HCW'(1) : held_reg;
        wr_slot_next = (wr_slot_reg == AW'(DEPTH - 1)) ? '0 : wr_slot_reg + AW'(1);
        slot_wide    = SW'(s_slot);
        rd_addr      = is_push ? wr_slot_reg : slot_wide[AW-1:0];
    end

    // Request description handed to the sum stage.
    always_comb begin
        item_next.cmd          = s_cmd;
        item_next.sample       = s_sample;
        item_next.leave_sample = win_line_reg[WINDOW-1];
        item_next.sub_old      = is_push && ring_full;
        item_next.sub_leave    = is_push && win_full;
        item_next.full_after   = (held_next == HCW'(DEPTH));
        item_next.win_after    = (WINDOW <= DEPTH) && (32'(held_next) >= 32'(WINDOW));
        item_next.read_ok      = !is_push && (32'(s_slot) < 32'(held_reg));
        item_next.fill         = FILL_W'(held_next);
    end

    // Ring memory: a push writes its slot and reads out the old value at the same edge; a read reads its slot.
    always_ff @(posedge aclk) begin
        if (accept) begin
            if (is_push) begin
                ring_mem[wr_slot_reg] <= s_sample;
            end
            rd_data_reg <= ring_mem[rd_addr];
        end
    end

    // Delay line of the most recent pushes, its last tap leaves the window.
    always_ff @(posedge aclk) begin
        if (accept && is_push) begin
            win_line_reg[0] <= s_sample;
            for (int i = 1; i < WINDOW; i++) begin
                win_line_reg[i] <= win_line_reg[i-1];
            end
        end
    end

    // Control state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
            held_reg    <= '0;
            wr_slot_reg <= '0;
        end else begin
            if (s_tready) begin
                a_valid_reg <= s_tvalid;
            end
            if (accept && is_push) begin
                held_reg    <= held_next;
                wr_slot_reg <= wr_slot_next;
            end
        end
    end

    // Stage payload.
    always_ff @(posedge aclk) begin
        if (accept) begin
            a_item_reg <= item_next;
        end
    end

    assign a_valid    = a_valid_reg;
    assign a_item     = a_item_reg;
    assign a_mem_data = rd_data_reg;

endmodule

[design/rwsd_accum.sv]
// Running total and window sums, updated once per request.
module rwsd_accum #(
    parameter int DEPTH  = rwsd_pkg::DEPTH_DEFAULT,
    parameter int WINDOW = rwsd_pkg::WINDOW_DEFAULT
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   a_valid,
    input  rwsd_pkg::a_item_t                      a_item,
    input  logic signed [rwsd_pkg::SAMPLE_W-1:0]   a_mem_data,
    input  logic                                   c_ready,
    output logic                                   b_ready,
    output logic                                   b_valid,
    output rwsd_pkg::b_item_t                      b_item,
    output logic signed [15+$clog2(DEPTH):0]       total,
    output logic signed [15+$clog2(WINDOW):0]      window
);
    import rwsd_pkg::*;

    localparam int TSW = SAMPLE_W + $clog2(DEPTH);
    localparam int WSW = SAMPLE_W + $clog2(WINDOW);

    logic signed [TSW-1:0] total_reg;
    logic signed [TSW-1:0] total_next;
    logic signed [WSW-1:0] window_reg;
    logic signed [WSW-1:0] window_next;
    logic                  b_valid_reg;
    b_item_t               b_item_reg;
    b_item_t               b_item_next;
    logic                  load;
    logic                  is_push;

    assign b_ready = !b_valid_reg || c_ready;
    assign load    = a_valid && b_ready;
    assign is_push = (a_item.cmd == CMD_PUSH);

    // One add and one subtract per sum.
    always_comb begin
        total_next  = total_reg;
        window_next = window_reg;
        if (is_push) begin
            total_next = total_reg + TSW'(a_item.sample)
                         - (a_item.sub_old ? TSW'(a_mem_data) : TSW'(0));
            window_next = window_reg + WSW'(a_item.sample)
                          - (a_item.sub_leave ? WSW'(a_item.leave_sample) : WSW'(0));
        end
        b_item_next.full       = a_item.full_after;
        b_item_next.win_ready  = a_item.win_after;
        b_item_next.read_ok    = a_item.read_ok;
        b_item_next.read_value = a_item.read_ok ? a_mem_data : '0;
        b_item_next.fill       = a_item.fill;
    end

    // Sums are block state and reset to zero.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b_valid_reg <= 1'b0;
            total_reg   <= '0;
            window_reg  <= '0;
        end else begin
            if (b_ready) begin
                b_valid_reg <= a_valid;
            end
            if (load) begin
                total_reg  <= total_next;
                window_reg <= window_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            b_item_reg <= b_item_next;
        end
    end

    assign b_valid = b_valid_reg;
    assign b_item  = b_item_reg;
    assign total   = total_reg;
    assign window  = window_reg;

endmodule

[design/rwsd_eval.sv]
// Threshold compares and the result register.
module rwsd_eval #(
    parameter int DEPTH  = rwsd_pkg::DEPTH_DEFAULT,
    parameter int WINDOW = rwsd_pkg::WINDOW_DEFAULT
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   b_valid,
    input  rwsd_pkg::b_item_t                      b_item,
    input  logic signed [15+$clog2(DEPTH):0]       total,
    input  logic signed [15+$clog2(WINDOW):0]      window,
    input  logic [rwsd_pkg::MEAN_LIMIT_W-1:0]      mean_limit,
    input  logic [rwsd_pkg::WIN_LIMIT_W-1:0]       low_limit,
    input  logic [rwsd_pkg::WIN_LIMIT_W-1:0]       high_limit,
    output logic                                   c_ready,
    output logic                                   m_tvalid,
    input  logic                                   m_tready,
    output logic [rwsd_pkg::M_TDATA_W-1:0]         m_tdata
);
    import rwsd_pkg::*;

    localparam int TSW  = SAMPLE_W + $clog2(DEPTH);
    localparam int WSW  = SAMPLE_W + $clog2(WINDOW);
    localparam int CMPW = (WSW > WIN_LIMIT_W) ? WSW : WIN_LIMIT_W;

    logic [TSW-1:0]  mean_bound_reg;
    logic [TSW-1:0]  total_abs;
    logic [WSW-1:0]  window_abs;
    logic            m_valid_reg;
    result_t         m_data_reg;
    result_t         result_next;
    logic            load;

    assign c_ready = !m_valid_reg || m_tready;
    assign load    = b_valid && c_ready;

    // Mean bound is DEPTH times the limit; registered off the config path.
    always_ff @(posedge aclk) begin
        mean_bound_reg <= TSW'(DEPTH) * TSW'(mean_limit);
    end

    // Magnitudes and event codes.
    always_comb begin
        total_abs  = total[TSW-1] ? TSW'(-total) : TSW'(total);
        window_abs = window[WSW-1] ? WSW'(-window) : WSW'(window);

        result_next.pad        = '0;
        result_next.fill_count = b_item.fill;
        result_next.read_valid = b_item.read_ok;
        result_next.read_value = b_item.read_value;

        if (!b_item.full) begin
            result_next.mean_event = EV_NONE;
        end else if (total_abs <= mean_bound_reg) begin
            result_next.mean_event = EV_TRUE;
        end else begin
            result_next.mean_event = EV_FALSE;
        end

        if (!b_item.win_ready) begin
            result_next.low_window_event  = EV_NONE;
            result_next.high_window_event = EV_NONE;
        end else begin
            result_next.low_window_event =
                (CMPW'(window_abs) > CMPW'(low_limit)) ? EV_TRUE : EV_FALSE;
            result_next.high_window_event =
                (CMPW'(window_abs) > CMPW'(high_limit)) ? EV_TRUE : EV_FALSE;
        end
    end

    // Output register holds a result until the receiver takes it.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (c_ready) begin
            m_valid_reg <= b_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            m_data_reg <= result_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

endmodule
